// ===== hdl/bfsa_pkg.sv =====
package bfsa_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int ADDR_W    = 16;
    localparam int ID_W      = 16;
    localparam int TIME_W    = 32;
    localparam int FREED_W   = 6;

    typedef enum logic [2:0] {
        CMD_ALLOC   = 3'd0,
        CMD_FREE    = 3'd1,
        CMD_TICK    = 3'd2,
        CMD_COMPACT = 3'd3,
        CMD_HOLE    = 3'd4,
        CMD_EXISTS  = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_DUP_ID    = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN,
        S_DECIDE,
        S_INSERT,
        S_FILTER,
        S_REBASE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [ID_W-1:0]   proc_id;
        logic [ADDR_W-1:0] req_size;
        logic [TIME_W-1:0] run_time;
        logic [TIME_W-1:0] elapsed;
    } t_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [ADDR_W-1:0]  base_addr;
        logic [ADDR_W-1:0]  hole_size;
        logic               found;
        logic [FREED_W-1:0] freed_count;
        logic [ADDR_W-1:0]  free_words;
        logic               any_resident;
    } t_result;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] size;
        logic [TIME_W-1:0] rtime;
    } t_seg;

    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic ins;
        logic filt;
        logic filt_end;
        logic reb;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       at_end;
        logic       ins_hit;
        logic       alloc_ok;
        logic       free_ok;
    } t_sts;

endpackage

// ===== hdl/bfsa_ctrl.sv =====
module bfsa_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bfsa_pkg::t_sts i_sts,
    output bfsa_pkg::t_ctl o_ctl,
    output logic          busy
);
    import bfsa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = S_DISPATCH;
            end
            S_DISPATCH: begin
                case (i_sts.cmd)
                    CMD_ALLOC, CMD_FREE, CMD_HOLE, CMD_EXISTS: n_state = S_SCAN;
                    CMD_TICK:    n_state = S_FILTER;
                    CMD_COMPACT: n_state = S_REBASE;
                    default:     n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (i_sts.at_end) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_sts.cmd == CMD_ALLOC && i_sts.alloc_ok) n_state = S_INSERT;
                else if (i_sts.cmd == CMD_FREE && i_sts.free_ok) n_state = S_FILTER;
                else n_state = S_DONE;
            end
            S_INSERT: begin
                if (i_sts.ins_hit) n_state = S_DONE;
            end
            S_FILTER: begin
                if (i_sts.at_end) n_state = S_DONE;
            end
            S_REBASE: begin
                if (i_sts.at_end) n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '0;
        busy  = 1'b1;
        case (r_state)
            S_IDLE: begin
                busy       = 1'b0;
                o_ctl.load = start;
            end
            S_SCAN:   o_ctl.scan   = 1'b1;
            S_DECIDE: o_ctl.decide = 1'b1;
            S_INSERT: o_ctl.ins    = 1'b1;
            S_FILTER: begin
                o_ctl.filt     = !i_sts.at_end;
                o_ctl.filt_end = i_sts.at_end;
            end
            S_REBASE: o_ctl.reb  = !i_sts.at_end;
            S_DONE:   o_ctl.emit = 1'b1;
            default:  o_ctl = '0;
        endcase
    end

endmodule

// ===== hdl/bfsa_datapath.sv =====
module bfsa_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bfsa_pkg::t_item   i_item,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  bfsa_pkg::t_ctl    i_ctl,
    output bfsa_pkg::t_sts    o_sts,
    output logic              o_valid,
    output bfsa_pkg::t_result o_result
);
    import bfsa_pkg::*;

    // segment table, kept sorted by base address
    t_seg r_seg [MAX_TASKS];

    logic [ADDR_W-1:0]  r_mem;
    logic [CNT_W-1:0]   r_count;
    logic [ADDR_W-1:0]  r_used;
    t_item              r_in;
    logic [CNT_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_wr;
    logic [ADDR_W-1:0]  r_cursor;
    logic               r_best_found;
    logic [ADDR_W-1:0]  r_best_len;
    logic [ADDR_W-1:0]  r_best_base;
    logic [CNT_W-1:0]   r_best_pos;
    logic               r_hit;
    logic [CNT_W-1:0]   r_hit_pos;
    logic [FREED_W-1:0] r_freed;
    t_status            r_status;
    logic [ADDR_W-1:0]  r_base_out;
    logic [ADDR_W-1:0]  r_hole_out;
    logic               r_found_out;
    logic               r_valid;
    t_result            r_result;

    logic [CNT_W-1:0]  rd_ptr;
    t_seg              rd;
    logic              at_end;
    logic [ADDR_W-1:0] limit;
    logic [ADDR_W-1:0] gap;
    logic              fits;
    logic              drop;
    logic              is_tick;
    logic              alloc_ok;
    t_seg              kept;
    t_seg              fresh;

    assign rd_ptr  = i_ctl.ins ? (r_idx - CNT_W'(1)) : r_idx;
    assign rd      = r_seg[rd_ptr[IDX_W-1:0]];
    assign at_end  = (r_idx == r_count);
    assign limit   = at_end ? r_mem : rd.base;
    assign gap     = limit - r_cursor;
    assign fits    = (gap != '0) && (gap >= r_in.req_size) &&
                     (!r_best_found || gap < r_best_len);
    assign is_tick = (r_in.cmd == CMD_TICK);
    assign drop    = is_tick ? (rd.rtime <= r_in.elapsed) : (r_idx == r_hit_pos);
    assign alloc_ok = !r_hit && (r_count != CNT_W'(MAX_TASKS)) &&
                      (r_in.req_size != '0) && r_best_found;

    always_comb begin
        kept = rd;
        if (is_tick) kept.rtime = rd.rtime - r_in.elapsed;
        fresh.id    = r_in.proc_id;
        fresh.base  = r_best_base;
        fresh.size  = r_in.req_size;
        fresh.rtime = r_in.run_time;
    end

    always_comb begin
        o_sts.cmd      = r_in.cmd;
        o_sts.at_end   = at_end;
        o_sts.ins_hit  = (r_idx == r_best_pos);
        o_sts.alloc_ok = alloc_ok;
        o_sts.free_ok  = r_hit;
    end

    // table writes: one port
    always_ff @(posedge i_clk) begin
        if (i_ctl.ins) begin
            if (r_idx == r_best_pos) r_seg[r_idx[IDX_W-1:0]] <= fresh;
            else r_seg[r_idx[IDX_W-1:0]] <= rd;
        end else if (i_ctl.filt && !drop) begin
            r_seg[r_wr[IDX_W-1:0]] <= kept;
        end else if (i_ctl.reb) begin
            r_seg[r_idx[IDX_W-1:0]] <= '{id: rd.id, base: r_cursor, size: rd.size,
                                         rtime: rd.rtime};
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_in         <= i_item;
            r_idx        <= '0;
            r_wr         <= '0;
            r_cursor     <= '0;
            r_best_found <= 1'b0;
            r_best_len   <= '0;
            r_best_base  <= '0;
            r_best_pos   <= '0;
            r_hit        <= 1'b0;
            r_hit_pos    <= '0;
            r_freed      <= '0;
            r_status     <= ST_OK;
            r_base_out   <= '0;
            r_hole_out   <= '0;
            r_found_out  <= 1'b0;
        end
        if (i_ctl.scan) begin
            if (fits) begin
                r_best_found <= 1'b1;
                r_best_len   <= gap;
                r_best_base  <= r_cursor;
                r_best_pos   <= r_idx;
            end
            if (!at_end) begin
                if (rd.id == r_in.proc_id && !r_hit) begin
                    r_hit     <= 1'b1;
                    r_hit_pos <= r_idx;
                end
                r_cursor <= rd.base + rd.size;
                r_idx    <= r_idx + CNT_W'(1);
            end
        end
        if (i_ctl.decide) begin
            // free walks up from the bottom, insert walks down from the top
            r_idx <= (r_in.cmd == CMD_FREE) ? '0 : r_count;
            r_wr  <= '0;
            case (r_in.cmd)
                CMD_ALLOC: begin
                    if (r_hit) r_status <= ST_DUP_ID;
                    else if (r_count == CNT_W'(MAX_TASKS)) r_status <= ST_FULL;
                    else if (!alloc_ok) r_status <= ST_NO_FIT;
                    else begin
                        r_base_out <= r_best_base;
                    end
                end
                CMD_FREE: begin
                    if (!r_hit) r_status <= ST_NOT_FOUND;
                end
                CMD_HOLE: begin
                    if (r_best_found) begin
                        r_hole_out  <= r_best_len;
                        r_found_out <= 1'b1;
                    end else begin
                        r_status <= ST_NO_FIT;
                    end
                end
                CMD_EXISTS: r_found_out <= r_hit;
                default: r_status <= ST_OK;
            endcase
        end
        if (i_ctl.ins && r_idx != r_best_pos) r_idx <= r_idx - CNT_W'(1);
        if (i_ctl.filt) begin
            r_idx <= r_idx + CNT_W'(1);
            if (!drop) r_wr <= r_wr + CNT_W'(1);
            else if (is_tick) r_freed <= r_freed + FREED_W'(1);
        end
        if (i_ctl.reb) begin
            r_cursor <= r_cursor + rd.size;
            r_idx    <= r_idx + CNT_W'(1);
        end
        if (i_ctl.emit) begin
            r_result.status       <= r_status;
            r_result.base_addr    <= r_base_out;
            r_result.hole_size    <= r_hole_out;
            r_result.found        <= r_found_out;
            r_result.freed_count  <= r_freed;
            r_result.free_words   <= r_mem - r_used;
            r_result.any_resident <= (r_count != '0);
        end
    end

    // store bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mem   <= 16'hFFFF;
            r_count <= '0;
            r_used  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.emit;
            if (i_cfg_we) begin
                r_mem   <= i_cfg_data;
                r_count <= '0;
                r_used  <= '0;
            end else if (i_ctl.ins && r_idx == r_best_pos) begin
                r_count <= r_count + CNT_W'(1);
                r_used  <= r_used + r_in.req_size;
            end else if (i_ctl.filt && drop) begin
                r_used  <= r_used - rd.size;
            end else if (i_ctl.filt_end) begin
                r_count <= r_wr;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hdl/best_fit_segment_allocator.sv =====
// channel   | direction | handshake                       | payload
// ----------+-----------+---------------------------------+----------------
// command   | in        | start high while busy low       | i_item
// result    | out       | o_valid, one cycle, no stall    | o_result
// config    | in        | i_cfg_we, no wait               | i_cfg_data
//
// commands walk the segment table one entry per cycle: first a scan of gaps and ids,
// then at most one more pass to insert, filter or rebase; tick and compact do only
// that second pass, with no scan
// reset is synchronous, active low: empty table, memory_words = 65535
// the receiver cannot stall; each transaction gives exactly one result
module best_fit_segment_allocator (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  bfsa_pkg::t_item    i_item,
    output logic               busy,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output bfsa_pkg::t_result  o_result
);
    import bfsa_pkg::*;

    // command bundle from the sequencer, status back from the datapath
    t_ctl ctl;
    t_sts sts;

    // sequencer: scan and decide, then at most one table pass; tick and compact skip the scan
    bfsa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_ctl   (ctl),
        .busy    (busy)
    );

    // sorted segment table, gap search and result registers
    bfsa_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_ctl      (ctl),
        .o_sts      (sts),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ===== hdl/bfsa_checker.sv =====
module bfsa_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_valid,
    input bfsa_pkg::t_result o_result
);
    import bfsa_pkg::*;

    // a result only ever arrives once the sequencer is back to idle
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy) else $error("result while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted transaction not taken up");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> !o_valid) else $error("result without transaction");

    a_base_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status != ST_OK) |-> (o_result.base_addr == '0))
        else $error("base on failed transaction");

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);

// ===== tb/best_fit_segment_allocator_test.sv =====
`timescale 1ns / 100ps

module best_fit_segment_allocator_test;

    import bfsa_pkg::*;

    // command codes the block ignores
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int NUM_HOLES  = MAX_TASKS + 1;
    localparam int STALL_LIMIT = 4000;   // cycles with no transaction before giving up

    // shadow of the segment and hole tables; predicts one result per command
    class segment_table_model;
        bit          seg_live[MAX_TASKS];
        logic [15:0] seg_ident[MAX_TASKS];
        int          seg_at[MAX_TASKS];
        int          seg_len[MAX_TASKS];
        logic [31:0] seg_left[MAX_TASKS];
        bit          gap_live[NUM_HOLES];
        int          gap_at[NUM_HOLES];
        int          gap_len[NUM_HOLES];
        int          words_total;
        int          words_free;
        t_result     expected_results[$];
        int          mismatches;

        function void set_memory(int words);
            words_total = words;
            foreach (seg_live[i]) seg_live[i] = 0;
            recount_gaps();
        endfunction

        function int sort_by_base(ref int ord[MAX_TASKS]);
            int n, j;
            n = 0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (!seg_live[i]) continue;
                j = n;
                while (j > 0 && seg_at[ord[j-1]] > seg_at[i]) begin
                    ord[j] = ord[j-1];
                    j--;
                end
                ord[j] = i;
                n++;
            end
            return n;
        endfunction

        // holes are the maximal gaps between live tasks
        function void recount_gaps();
            int ord[MAX_TASKS];
            int n, k, cursor, lim;
            n = sort_by_base(ord);
            k = 0;
            cursor = 0;
            words_free = 0;
            foreach (gap_live[h]) gap_live[h] = 0;
            for (int i = 0; i <= n; i++) begin
                lim = (i < n) ? seg_at[ord[i]] : words_total;
                if (lim > cursor && k < NUM_HOLES) begin
                    gap_live[k] = 1;
                    gap_at[k] = cursor;
                    gap_len[k] = lim - cursor;
                    words_free += lim - cursor;
                    k++;
                end
                if (i < n) cursor = seg_at[ord[i]] + seg_len[ord[i]];
            end
        endfunction

        function int best_gap(int req);
            int best;
            best = -1;
            for (int h = 0; h < NUM_HOLES; h++) begin
                if (!gap_live[h] || gap_len[h] < req) continue;
                if (best < 0 || gap_len[h] < gap_len[best] ||
                    (gap_len[h] == gap_len[best] && gap_at[h] < gap_at[best]))
                    best = h;
            end
            return best;
        endfunction

        function int slot_of(logic [15:0] id);
            for (int i = 0; i < MAX_TASKS; i++)
                if (seg_live[i] && seg_ident[i] == id) return i;
            return -1;
        endfunction

        function void note_command(t_item it);
            t_result r;
            int slot, h, i, n, cursor;
            int ord[MAX_TASKS];
            r = '0;
            case (it.cmd)
                CMD_ALLOC: begin
                    slot = -1;
                    for (i = 0; i < MAX_TASKS; i++)
                        if (!seg_live[i] && slot < 0) slot = i;
                    h = (it.req_size == 0) ? -1 : best_gap(int'(it.req_size));
                    if (slot_of(it.proc_id) >= 0) r.status = ST_DUP_ID;
                    else if (slot < 0) r.status = ST_FULL;
                    else if (h < 0) r.status = ST_NO_FIT;
                    else begin
                        seg_live[slot] = 1;
                        seg_ident[slot] = it.proc_id;
                        seg_at[slot] = gap_at[h];
                        seg_len[slot] = int'(it.req_size);
                        seg_left[slot] = it.run_time;
                        r.base_addr = 16'(gap_at[h]);
                        recount_gaps();
                    end
                end
                CMD_FREE: begin
                    i = slot_of(it.proc_id);
                    if (i < 0) r.status = ST_NOT_FOUND;
                    else begin
                        seg_live[i] = 0;
                        recount_gaps();
                    end
                end
                CMD_TICK: begin
                    for (i = 0; i < MAX_TASKS; i++) begin
                        if (!seg_live[i]) continue;
                        if (seg_left[i] <= it.elapsed) begin
                            seg_live[i] = 0;
                            r.freed_count++;
                        end else seg_left[i] -= it.elapsed;
                    end
                    recount_gaps();
                end
                CMD_COMPACT: begin
                    n = sort_by_base(ord);
                    cursor = 0;
                    for (i = 0; i < n; i++) begin
                        seg_at[ord[i]] = cursor;
                        cursor += seg_len[ord[i]];
                    end
                    recount_gaps();
                end
                CMD_HOLE: begin
                    h = best_gap(int'(it.req_size));
                    if (h < 0) r.status = ST_NO_FIT;
                    else begin
                        r.hole_size = 16'(gap_len[h]);
                        r.found = 1;
                    end
                end
                CMD_EXISTS: r.found = (slot_of(it.proc_id) >= 0);
                default: ;
            endcase
            r.free_words = 16'(words_free);
            for (i = 0; i < MAX_TASKS; i++)
                if (seg_live[i]) r.any_resident = 1;
            expected_results.push_back(r);
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with nothing expected: %p", got);
                return;
            end
            e = expected_results.pop_front();
            if (got.status !== e.status || got.base_addr !== e.base_addr ||
                got.hole_size !== e.hole_size || got.found !== e.found ||
                got.freed_count !== e.freed_count || got.free_words !== e.free_words ||
                got.any_resident !== e.any_resident) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch at %0t\n  expected %p\n  actual   %p",
                             $realtime, e, got);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    t_item       i_item;
    logic        busy;
    logic        i_cfg_we;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    t_result     o_result;

    segment_table_model table_model;
    int idle_cycles;
    int sender_idle_pct;
    int memory_size;

    best_fit_segment_allocator DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_item    (i_item),
        .busy      (busy),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_data(i_cfg_data),
        .o_valid   (o_valid),
        .o_result  (o_result)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // every edge: note accepted commands, check strobed results, run the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                table_model.note_command(i_item);
            end
            if (o_valid) begin
                table_model.check_result(o_result);
            end
            if ((start && !busy) || o_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // one command transaction; start is left high so the next command can follow back-to-back
    task automatic issue(t_item it);
        i_item <= it;
        start  <= 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic issue_fields(logic [2:0] cmd, logic [15:0] id, logic [15:0] sz,
                                logic [31:0] run, logic [31:0] el);
        t_item it;
        it.cmd = cmd;
        it.proc_id = id;
        it.req_size = sz;
        it.run_time = run;
        it.elapsed = el;
        issue(it);
    endtask

    // hold off the sender until every outstanding transaction has returned
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (table_model.expected_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_memory_size(int words);
        drain();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= words[15:0];
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        table_model.set_memory(words);
        memory_size = words;
    endtask

    // mostly allocate, free and tick over a small id pool so the table fills and empties
    function automatic t_item random_command();
        t_item it;
        int pick;
        pick = $urandom_range(99);
        it.proc_id  = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
        it.req_size = 16'($urandom_range(1, memory_size / 6 + 1));
        if ($urandom_range(24) == 0) it.req_size = 16'($urandom);
        it.run_time = ($urandom_range(14) == 0) ? $urandom : $urandom_range(1, 30);
        it.elapsed  = ($urandom_range(14) == 0) ? $urandom : $urandom_range(0, 4);
        if (pick < 42) it.cmd = CMD_ALLOC;
        else if (pick < 60) it.cmd = CMD_FREE;
        else if (pick < 74) it.cmd = CMD_TICK;
        else if (pick < 80) it.cmd = CMD_COMPACT;
        else if (pick < 89) it.cmd = CMD_HOLE;
        else if (pick < 97) it.cmd = CMD_EXISTS;
        else it.cmd = pick[0] ? CMD_SPARE_A : CMD_SPARE_B;
        return it;
    endfunction

    task automatic random_phase(int count, int idle_pct);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            issue(random_command());
            if ($urandom_range(199) == 0) drain();
        end
        drain();
    endtask

    initial begin
        table_model = new();
        table_model.set_memory(65535);
        memory_size     = 65535;
        idle_cycles     = 0;
        sender_idle_pct = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, every command and the listed corner cases
        issue_fields(CMD_ALLOC,   16'h0000, 16'd1,     32'd1,          32'd0);
        issue_fields(CMD_ALLOC,   16'hFFFF, 16'hFFFF,  32'hFFFF_FFFF,  32'd0);  // no fit
        issue_fields(CMD_ALLOC,   16'h0001, 16'd0,     32'd5,          32'd0);  // zero size
        issue_fields(CMD_ALLOC,   16'h0000, 16'd3,     32'd5,          32'd0);  // duplicate
        issue_fields(CMD_ALLOC,   16'h0002, 16'd100,   32'hFFFF_FFFF,  32'd0);
        issue_fields(CMD_ALLOC,   16'h0003, 16'd100,   32'd3,          32'd0);
        issue_fields(CMD_FREE,    16'h0002, 16'd0,     32'd0,          32'd0);
        issue_fields(CMD_FREE,    16'h7777, 16'd0,     32'd0,          32'd0);  // unknown id
        issue_fields(CMD_HOLE,    16'd0,    16'd50,    32'd0,          32'd0);
        issue_fields(CMD_HOLE,    16'd0,    16'hFFFF,  32'd0,          32'd0);  // no fit
        issue_fields(CMD_EXISTS,  16'h0003, 16'd0,     32'd0,          32'd0);
        issue_fields(CMD_EXISTS,  16'h0002, 16'd0,     32'd0,          32'd0);
        issue_fields(CMD_TICK,    16'd0,    16'd0,     32'd0,          32'd0);
        issue_fields(CMD_TICK,    16'd0,    16'd0,     32'd0,          32'd3);  // expiry at equal
        issue_fields(CMD_COMPACT, 16'd0,    16'd0,     32'd0,          32'd0);
        issue_fields(CMD_SPARE_A, 16'hFFFF, 16'hFFFF,  32'hFFFF_FFFF,  32'hFFFF_FFFF);
        issue_fields(CMD_SPARE_B, 16'd0,    16'd0,     32'd0,          32'd0);
        issue_fields(CMD_TICK,    16'd0,    16'd0,     32'd0,          32'hFFFF_FFFF);
        write_memory_size(0);  // nothing fits with zero memory
        issue_fields(CMD_ALLOC,   16'h0005, 16'd1,     32'd1,          32'd0);
        issue_fields(CMD_HOLE,    16'd0,    16'd0,     32'd0,          32'd0);
        write_memory_size(1);
        issue_fields(CMD_ALLOC,   16'h0005, 16'd1,     32'd1,          32'd0);
        issue_fields(CMD_ALLOC,   16'h0006, 16'd1,     32'd1,          32'd0);

        // random phases, sender idling varied; receiver has no stall to apply
        write_memory_size(200);
        random_phase(400, 0);
        write_memory_size(65535);
        random_phase(350, 64);
        write_memory_size(1000);
        random_phase(350, 15);
        write_memory_size(1);
        random_phase(80, 0);
        write_memory_size(37);
        random_phase(320, 64);

        drain();
        repeat (100) @(posedge i_clk);
        if (table_model.expected_results.size() != 0) table_model.mismatches++;
        if (table_model.mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
